### rtl/core/bmhq_pkg.sv
// Package for the binary min-heap queue: operation and status codes, types.
// No dependencies.
`default_nettype none
package bmhq_pkg;
    localparam int unsigned KeyW = 32;
    localparam int unsigned HandleW = 16;
    localparam int unsigned CapW = 11;
    localparam logic [CapW-1:0] MinCapacity = 11'd10;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic start;
        logic up_step;
        logic down_read;
        logic down_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_full;
        logic is_empty;
        logic up_done;
        logic down_done;
    } t_sts;
endpackage
`default_nettype wire

### rtl/core/bmhq_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface bmhq_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/binary_min_heap_queue.sv
// Binary min-heap queue, top level: handshake channels, config register,
// controller and datapath. Read, clear and refused full/empty items go straight to the result;
// insert climbs one level per up step, delete reads the children and steps once per level descended.
// One item at a time; the next item is taken the cycle after its result is accepted.
// Reset empties the heap and sets the capacity to 1024; heap slots are undefined until written.
`default_nettype none
module binary_min_heap_queue #(
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [bmhq_pkg::CapW-1:0]    i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_kind,
    input  wire logic [bmhq_pkg::KeyW-1:0]    i_new_key,
    input  wire logic [bmhq_pkg::HandleW-1:0] i_new_handle,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [1:0]                        o_status,
    output logic [bmhq_pkg::KeyW-1:0]         o_out_key,
    output logic [bmhq_pkg::HandleW-1:0]      o_out_handle,
    output logic [bmhq_pkg::CapW-1:0]         o_entry_total
);
    logic [bmhq_pkg::CapW-1:0] r_cap;
    bmhq_pkg::t_cmd cmd;
    bmhq_pkg::t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 11'd1024;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    bmhq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_kind(bmhq_pkg::t_op'(i_kind)), .i_sts(sts), .o_cmd(cmd)
    );

    bmhq_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_cap(r_cap), .i_kind(bmhq_pkg::t_op'(i_kind)),
        .i_key(i_new_key), .i_handle(i_new_handle), .i_cmd(cmd), .o_sts(sts),
        .o_status, .o_key(o_out_key), .o_handle(o_out_handle), .o_total(o_entry_total)
    );

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and result valid together");
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_total <= 11'(DEPTH)) else $error("entry total above depth");
    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == bmhq_pkg::ST_FULL |-> o_out_key == '0)
        else $error("full result carries data");
`endif
endmodule
`default_nettype wire

### rtl/core/bmhq_ctrl.sv
// Controller state machine for the heap queue.
// Depends on bmhq_pkg; drives commands to bmhq_dp.
`default_nettype none
module bmhq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire bmhq_pkg::t_op i_kind,
    input  wire bmhq_pkg::t_sts i_sts,
    output bmhq_pkg::t_cmd     o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_UP    = 5'b00010,
        S_DRD   = 5'b00100,
        S_DSTEP = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    if (i_kind == bmhq_pkg::OP_INSERT && !i_sts.is_full) begin
                        n_state = S_UP;
                    end else if (i_kind == bmhq_pkg::OP_DELETE && !i_sts.is_empty) begin
                        n_state = S_DRD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_UP: begin
                o_cmd.up_step = 1'b1;
                if (i_sts.up_done) begin
                    n_state = S_OUT;
                end
            end
            S_DRD: begin
                o_cmd.down_read = 1'b1;
                n_state = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.down_step = 1'b1;
                n_state = i_sts.down_done ? S_OUT : S_DRD;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

### rtl/core/bmhq_dp.sv
// Datapath for the heap queue: heap memory, count, position and result registers.
// Depends on bmhq_pkg; commanded by bmhq_ctrl.
`default_nettype none
module bmhq_dp #(
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [bmhq_pkg::CapW-1:0]      i_cap,
    input  wire bmhq_pkg::t_op                  i_kind,
    input  wire logic [bmhq_pkg::KeyW-1:0]      i_key,
    input  wire logic [bmhq_pkg::HandleW-1:0]   i_handle,
    input  wire bmhq_pkg::t_cmd                 i_cmd,
    output bmhq_pkg::t_sts                      o_sts,
    output logic [1:0]                          o_status,
    output logic [bmhq_pkg::KeyW-1:0]           o_key,
    output logic [bmhq_pkg::HandleW-1:0]        o_handle,
    output logic [bmhq_pkg::CapW-1:0]           o_total
);
    localparam int unsigned PW = $clog2(DEPTH + 1);
    localparam int unsigned EW = bmhq_pkg::KeyW + bmhq_pkg::HandleW;
    localparam int unsigned CW = (PW > bmhq_pkg::CapW) ? PW : bmhq_pkg::CapW;

    // Slot 0 is unused; the root lives at slot 1.
    logic [EW-1:0] mem [0:DEPTH];

    logic [PW-1:0] r_count, r_pos;
    logic [EW-1:0] r_ent, r_rd0, r_rd1;
    logic [1:0]    r_status;
    logic [EW-1:0] r_res;
    logic          r_have_r;
    logic          r_first;

    logic [CW-1:0] cap_c, cnt_c, eff_cap;
    logic [PW:0]   kid, kid1;
    logic          has_r, pick_r, up_move, dn_move;
    logic [PW-1:0] parent;
    logic [EW-1:0] child;
    logic [PW-1:0] child_pos;

    always_comb begin
        cap_c = CW'(i_cap);
        cnt_c = CW'(r_count);
        if (cap_c < CW'(bmhq_pkg::MinCapacity)) begin
            eff_cap = CW'(bmhq_pkg::MinCapacity);
        end else if (cap_c > CW'(DEPTH)) begin
            eff_cap = CW'(DEPTH);
        end else begin
            eff_cap = cap_c;
        end
    end

    assign parent   = r_pos >> 1;
    assign up_move  = (r_pos > PW'(1)) &&
                      (r_ent[EW-1 -: bmhq_pkg::KeyW] < r_rd0[EW-1 -: bmhq_pkg::KeyW]);
    assign kid      = {r_pos, 1'b0};
    assign kid1     = kid + (PW+1)'(1);
    assign has_r    = kid1 <= {1'b0, r_count};
    assign pick_r   = r_have_r &&
                      (r_rd1[EW-1 -: bmhq_pkg::KeyW] < r_rd0[EW-1 -: bmhq_pkg::KeyW]);
    assign child    = pick_r ? r_rd1 : r_rd0;
    assign child_pos = pick_r ? kid1[PW-1:0] : kid[PW-1:0];
    assign dn_move  = child[EW-1 -: bmhq_pkg::KeyW] < r_ent[EW-1 -: bmhq_pkg::KeyW];

    always_comb begin
        o_sts.is_full   = cnt_c >= eff_cap;
        o_sts.is_empty  = (r_count == '0);
        o_sts.up_done   = !up_move;
        o_sts.down_done = !(kid <= {1'b0, r_count}) || !dn_move;
    end

    // Memory port: one write and up to two reads per cycle, all registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rd0 <= mem[(i_kind == bmhq_pkg::OP_INSERT) ? (r_count + PW'(1)) >> 1 : r_count];
            r_ent <= {i_key, i_handle};
            if (i_kind == bmhq_pkg::OP_INSERT && !o_sts.is_full) begin
                r_res <= {i_key, i_handle};
            end else if ((i_kind == bmhq_pkg::OP_DELETE || i_kind == bmhq_pkg::OP_READ)
                         && !o_sts.is_empty) begin
                r_res <= mem[1];
            end else begin
                r_res <= '0;
            end
        end else if (i_cmd.up_step) begin
            if (up_move) begin
                mem[r_pos] <= r_rd0;
                r_rd0 <= mem[parent >> 1];
            end else begin
                mem[r_pos] <= r_ent;
            end
        end else if (i_cmd.down_read) begin
            if (kid <= {1'b0, r_count}) begin
                r_rd0 <= mem[kid[PW-1:0]];
                r_rd1 <= mem[kid1[PW-1:0]];
            end
            r_have_r <= has_r;
            if (r_first) begin
                r_ent <= r_rd0;
            end
        end else if (i_cmd.down_step) begin
            if ((kid <= {1'b0, r_count}) && dn_move) begin
                mem[r_pos] <= child;
            end else begin
                mem[r_pos] <= r_ent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_status <= bmhq_pkg::ST_OK;
            case (i_kind)
                bmhq_pkg::OP_INSERT: begin
                    if (o_sts.is_full) begin
                        r_status <= bmhq_pkg::ST_FULL;
                    end else begin
                        r_pos <= r_count + PW'(1);
                    end
                end
                bmhq_pkg::OP_DELETE, bmhq_pkg::OP_READ: begin
                    if (o_sts.is_empty) begin
                        r_status <= bmhq_pkg::ST_EMPTY;
                    end
                    r_pos <= PW'(1);
                end
                default: r_pos <= PW'(1);
            endcase
        end else if (i_cmd.up_step && up_move) begin
            r_pos <= parent;
        end else if (i_cmd.down_step && (kid <= {1'b0, r_count}) && dn_move) begin
            r_pos <= child_pos;
        end
    end

    // Entry count, and the flag that loads the last entry on the first delete step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_first <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_first <= 1'b0;
                case (i_kind)
                    bmhq_pkg::OP_INSERT: begin
                        if (!o_sts.is_full) r_count <= r_count + PW'(1);
                    end
                    bmhq_pkg::OP_DELETE: begin
                        if (!o_sts.is_empty) begin
                            r_count <= r_count - PW'(1);
                            r_first <= 1'b1;
                        end
                    end
                    bmhq_pkg::OP_READ: r_first <= 1'b0;
                    default: r_count <= '0;
                endcase
            end else if (r_first) begin
                r_first <= 1'b0;
            end
        end
    end

    assign o_status = r_status;
    assign o_key    = r_res[EW-1 -: bmhq_pkg::KeyW];
    assign o_handle = r_res[bmhq_pkg::HandleW-1:0];
    assign o_total  = bmhq_pkg::CapW'(r_count);
endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for binary_min_heap_queue: a directed table, then random phases.
// Results are compared with a min-heap predictor of its own.
// Depends on bmhq_pkg, bmhq_if and the block itself.
`default_nettype none
module tb_top;
    import bmhq_pkg::*;

    typedef struct packed {
        t_op                kind;
        logic [KeyW-1:0]    key;
        logic [HandleW-1:0] handle;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [KeyW-1:0]    key;
        logic [HandleW-1:0] handle;
        logic [CapW-1:0]    total;
    } t_rsp;

    typedef struct packed {
        logic typed;
        t_rsp rsp;
    } t_row_exp;

    typedef struct {
        t_req     req;
        t_row_exp exp;
    } t_row;

    localparam int unsigned HEAP_DEPTH = 1024;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    logic [CapW-1:0] cfg_data = '0;

    bmhq_if #(.T(t_req)) req_ch (.i_clk(i_clk));
    bmhq_if #(.T(t_rsp)) rsp_ch (.i_clk(i_clk));

    binary_min_heap_queue #(.DEPTH(HEAP_DEPTH)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (req_ch.valid),
        .o_in_ready    (req_ch.ready),
        .i_kind        (req_ch.data.kind),
        .i_new_key     (req_ch.data.key),
        .i_new_handle  (req_ch.data.handle),
        .o_out_valid   (rsp_ch.valid),
        .i_out_ready   (rsp_ch.ready),
        .o_status      (rsp_ch.data.status),
        .o_out_key     (rsp_ch.data.key),
        .o_out_handle  (rsp_ch.data.handle),
        .o_entry_total (rsp_ch.data.total)
    );

    always #5 i_clk = ~i_clk;

    logic [KeyW-1:0]    heap_key [1:HEAP_DEPTH];
    logic [HandleW-1:0] heap_hdl [1:HEAP_DEPTH];
    int unsigned        heap_count = 0;
    logic [CapW-1:0]    cap_reg = 11'd1024;

    t_rsp     rsp_q [$];
    t_row_exp typed_q [$];
    int       errors = 0;
    int       snd_idle = 0;
    int       rcv_idle = 0;
    logic     hold_start = 1'b0;
    int       hold_cnt = 0;
    int unsigned cycles = 0;
    int       n_full = 0;
    int       n_empty = 0;
    int       n_items = 0;

    function automatic int unsigned eff_capacity();
        int unsigned c;
        c = cap_reg;
        if (c < MinCapacity) c = MinCapacity;
        if (c > HEAP_DEPTH) c = HEAP_DEPTH;
        return c;
    endfunction

    function automatic t_rsp heap_apply(t_req r);
        t_rsp               o;
        int unsigned        pos;
        int unsigned        kid;
        logic [KeyW-1:0]    lk;
        logic [HandleW-1:0] lh;
        o = '{status: ST_OK, key: '0, handle: '0, total: '0};
        case (r.kind)
            OP_INSERT: begin
                if (heap_count >= eff_capacity()) begin
                    o.status = ST_FULL;
                end else begin
                    heap_count++;
                    pos = heap_count;
                    while (pos > 1 && r.key < heap_key[pos / 2]) begin
                        heap_key[pos] = heap_key[pos / 2];
                        heap_hdl[pos] = heap_hdl[pos / 2];
                        pos = pos / 2;
                    end
                    heap_key[pos] = r.key;
                    heap_hdl[pos] = r.handle;
                    o.key = r.key;
                    o.handle = r.handle;
                end
            end
            OP_DELETE, OP_READ: begin
                if (heap_count == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.key = heap_key[1];
                    o.handle = heap_hdl[1];
                    if (r.kind == OP_DELETE) begin
                        lk = heap_key[heap_count];
                        lh = heap_hdl[heap_count];
                        heap_count--;
                        pos = 1;
                        while (pos * 2 <= heap_count) begin
                            kid = pos * 2;
                            if (kid != heap_count && heap_key[kid + 1] < heap_key[kid]) kid++;
                            if (heap_key[kid] < lk) begin
                                heap_key[pos] = heap_key[kid];
                                heap_hdl[pos] = heap_hdl[kid];
                                pos = kid;
                            end else begin
                                break;
                            end
                        end
                        heap_key[pos] = lk;
                        heap_hdl[pos] = lh;
                    end
                end
            end
            default: begin
                heap_count = 0;
            end
        endcase
        o.total = heap_count[CapW-1:0];
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_rsp     p;
        t_row_exp e;
        cycles <= cycles + 1;
        if (i_rst_n && cfg_we) cap_reg = cfg_data;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            e = typed_q.pop_front();
            p = heap_apply(req_ch.data);
            if (p.status == ST_FULL) n_full++;
            if (p.status == ST_EMPTY) n_empty++;
            rsp_q.push_back(e.typed ? e.rsp : p);
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_q.size() == 0) begin
                $error("result with no expectation waiting");
                errors++;
            end else begin
                p = rsp_q.pop_front();
                if (rsp_ch.data.status !== p.status) begin
                    $error("status expected %0d actual %0d", p.status, rsp_ch.data.status);
                    errors++;
                end
                if (rsp_ch.data.key !== p.key) begin
                    $error("out_key expected %0h actual %0h", p.key, rsp_ch.data.key);
                    errors++;
                end
                if (rsp_ch.data.handle !== p.handle) begin
                    $error("out_handle expected %0h actual %0h", p.handle, rsp_ch.data.handle);
                    errors++;
                end
                if (rsp_ch.data.total !== p.total) begin
                    $error("entry_total expected %0d actual %0d", p.total, rsp_ch.data.total);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_cnt = 0;
        end else if (hold_start) begin
            hold_cnt = 400;
            rsp_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    task automatic send_item(t_req r, t_row_exp e);
        while ($urandom_range(99) < snd_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        typed_q.push_back(e);
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        n_items++;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain_and_write(logic [CapW-1:0] v);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (rsp_q.size() != 0 || typed_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_req rand_req(int ins_pct);
        t_req r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < ins_pct) r.kind = OP_INSERT;
        else if (pick < ins_pct + (97 - ins_pct) * 3 / 4) r.kind = OP_DELETE;
        else if (pick < 98) r.kind = OP_READ;
        else r.kind = OP_CLEAR;
        r.key = $urandom_range(1) ? $urandom : KeyW'($urandom_range(63));
        r.handle = HandleW'($urandom);
        return r;
    endfunction

    task automatic run_random(int count, int ins_pct);
        repeat (count) send_item(rand_req(ins_pct), '0);
    endtask

    function automatic t_row mk(t_op k, logic [KeyW-1:0] key, logic [HandleW-1:0] h,
                                logic typed, t_status st, logic [KeyW-1:0] ek,
                                logic [HandleW-1:0] eh, logic [CapW-1:0] et);
        t_row row;
        row.req = '{kind: k, key: key, handle: h};
        row.exp = '{typed: typed, rsp: '{status: st, key: ek, handle: eh, total: et}};
        return row;
    endfunction

    t_row stim [$];

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        stim.push_back(mk(OP_DELETE, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        stim.push_back(mk(OP_READ, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        stim.push_back(mk(OP_INSERT, '1, '1, 1, ST_OK, '1, '1, 1));
        stim.push_back(mk(OP_INSERT, 0, 0, 1, ST_OK, 0, 0, 2));
        stim.push_back(mk(OP_READ, 0, 0, 1, ST_OK, 0, 0, 2));
        stim.push_back(mk(OP_INSERT, 5, 16'h0001, 0, ST_OK, 0, 0, 0));
        stim.push_back(mk(OP_INSERT, 5, 16'h0002, 0, ST_OK, 0, 0, 0));
        stim.push_back(mk(OP_INSERT, 5, 16'h0003, 0, ST_OK, 0, 0, 0));
        for (int i = 0; i < 6; i++) stim.push_back(mk(OP_DELETE, 0, 0, 0, ST_OK, 0, 0, 0));
        stim.push_back(mk(OP_DELETE, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        stim.push_back(mk(OP_INSERT, 32'h8000_0000, 16'h8000, 0, ST_OK, 0, 0, 0));
        stim.push_back(mk(OP_INSERT, 32'h7FFF_FFFF, 16'h7FFF, 0, ST_OK, 0, 0, 0));
        stim.push_back(mk(OP_CLEAR, '1, '1, 1, ST_OK, 0, 0, 0));
        stim.push_back(mk(OP_READ, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        stim.push_back(mk(OP_CLEAR, 0, 0, 1, ST_OK, 0, 0, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim[i]) send_item(stim[i].req, stim[i].exp);

        // Capacity below the floor acts as ten entries.
        drain_and_write(11'd0);
        for (int i = 0; i < 10; i++) send_item(rand_req(100), '0);
        send_item('{kind: OP_INSERT, key: 1, handle: 1}, '{1'b1, '{ST_FULL, 0, 0, 10}});

        snd_idle = 38;
        rcv_idle = 76;
        run_random(150, 55);
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        run_random(40, 60);

        drain_and_write(11'd300);
        snd_idle = 76;
        rcv_idle = 38;
        send_item('{kind: OP_CLEAR, key: 0, handle: 0}, '0);
        run_random(200, 75);
        // Lowering the limit under the present count refuses further inserts.
        drain_and_write(11'd12);
        run_random(40, 50);

        drain_and_write(11'd2047);
        snd_idle = 0;
        rcv_idle = 0;
        send_item('{kind: OP_CLEAR, key: 0, handle: 0}, '0);
        run_random(400, 97);
        drain_and_write(11'($urandom_range(10, 1023)));
        run_random(40, 40);
        drain_and_write(11'd1024);
        run_random(250, 97);
        run_random(60, 20);

        req_ch.valid <= 1'b0;
        while (rsp_q.size() != 0 || typed_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Covered %0d items over capacities 0, 12, 300, 1024, 2047 and one random.",
                 n_items);
        $display("Full refusals: %0d, empty refusals: %0d.", n_full, n_empty);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
